[design/tfa_pkg.sv]
// shared types and constants for the tagged fixnum alu
package tfa_pkg;

    localparam int DIV_STEPS = 63;
    localparam int NSTG      = DIV_STEPS + 1;

    localparam logic [63:0] WORD_TRUE  = 64'd2;
    localparam logic [63:0] WORD_FALSE = 64'd4;
    localparam logic [63:0] WORD_ERR   = 64'd1;

    typedef enum logic [3:0] {
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_LT, K_LE, K_GT,
        K_GE, K_EQ, K_AND, K_OR, K_XOR, K_SHL, K_SHR, K_NOT
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_UNSUP = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_in_word;

    typedef struct packed {
        logic signed [63:0] result_word;
        logic [1:0]         status;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [63:0] res;
        t_status     st;
        logic        div_go;
        logic        q_neg;
        logic        r_neg;
        logic [63:0] rem;
        logic [62:0] quo;
        logic [62:0] dvs;
        logic [63:0] pll;
        logic [31:0] pxa;
        logic [31:0] pxb;
    } t_stage;

endpackage

[design/tagged_fixnum_alu_core.sv]
// tagged integer alu: pipelined arithmetic, compare, bitwise and divide
//
// Input channel i_in_valid / o_in_ready carries one word (kind, operand_a,
// operand_b); output channel o_out_valid / i_out_ready carries one word
// (result_word, status) per input word, in order.
// A word enters in every cycle while the output side takes results.
// From acceptance to the output register a word passes one input register,
// one decode stage with the partial products of the multiplier, 63
// restoring divide stages (one quotient bit each, a 64-bit subtract per
// stage) and the output register.
// Multiply is finished in the first divide stage; other operations ride
// along. All stages advance together; when the receiver stalls with a
// result waiting, the whole pipeline holds and o_in_ready drops, so nothing
// is lost or repeated. Bubbles stay in place while stalled.
// Reset (synchronous, active low) clears all valid bits; the block is
// ready as soon as reset is released.
module tagged_fixnum_alu_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tfa_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tfa_pkg::t_out_word  o_out_word
);
    import tfa_pkg::*;

    logic      w_en;
    logic      r_s0_valid;
    t_in_word  r_s0_word;
    t_stage    r_pipe [1:NSTG];
    t_stage    n_pipe [1:NSTG];
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    assign w_en        = !r_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_in_valid;
        end
        if (w_en) begin
            r_s0_word <= i_in_word;
        end
    end

    // decode stage
    logic [63:0] w_a, w_b, w_ua, w_ub, w_va, w_vb, w_v, w_na, w_nb;
    logic        w_both;

    assign w_a    = r_s0_word.operand_a;
    assign w_b    = r_s0_word.operand_b;
    assign w_ua   = {w_a[63], w_a[63:1]};
    assign w_ub   = {w_b[63], w_b[63:1]};
    assign w_both = w_a[0] & w_b[0];
    assign w_va   = w_a[0] ? w_ua : w_a;
    assign w_vb   = w_b[0] ? w_ub : w_b;
    assign w_na   = -w_ua;
    assign w_nb   = -w_ub;

    always_comb begin
        n_pipe[1]        = '0;
        n_pipe[1].valid  = r_s0_valid;
        n_pipe[1].kind   = t_kind'(r_s0_word.kind);
        n_pipe[1].res    = WORD_ERR;
        n_pipe[1].st     = ST_OK;
        n_pipe[1].q_neg  = w_ua[63] ^ w_ub[63];
        n_pipe[1].r_neg  = w_ua[63];
        n_pipe[1].quo    = w_ua[63] ? w_na[62:0] : w_ua[62:0];
        n_pipe[1].dvs    = w_ub[63] ? w_nb[62:0] : w_ub[62:0];
        n_pipe[1].pll    = 64'(w_ua[31:0] * w_ub[31:0]);
        n_pipe[1].pxa    = 32'(w_ua[63:32] * w_ub[31:0]);
        n_pipe[1].pxb    = 32'(w_ua[31:0] * w_ub[63:32]);
        w_v              = '0;
        case (n_pipe[1].kind) inside
            K_ADD: n_pipe[1].res = w_a + w_b - 64'd1;
            K_SUB: n_pipe[1].res = w_a - w_b + 64'd1;
            K_LT:  n_pipe[1].res = ($signed(w_ua) <  $signed(w_ub)) ? WORD_TRUE : WORD_FALSE;
            K_LE:  n_pipe[1].res = ($signed(w_ua) <= $signed(w_ub)) ? WORD_TRUE : WORD_FALSE;
            K_GT:  n_pipe[1].res = ($signed(w_ua) >  $signed(w_ub)) ? WORD_TRUE : WORD_FALSE;
            K_GE:  n_pipe[1].res = ($signed(w_ua) >= $signed(w_ub)) ? WORD_TRUE : WORD_FALSE;
            K_DIV, K_MOD: begin
                if (w_ub == '0) begin
                    n_pipe[1].st = ST_DIV0;
                end else begin
                    n_pipe[1].div_go = 1'b1;
                end
            end
            K_EQ: begin
                if (w_a == w_b) begin
                    n_pipe[1].res = WORD_TRUE;
                end else if ((w_a == 64'd0 && w_b == 64'd1) ||
                             (w_a == 64'd1 && w_b == 64'd0)) begin
                    n_pipe[1].res = WORD_TRUE;
                end else if (w_a[0] != w_b[0] || w_a[0]) begin
                    n_pipe[1].res = WORD_FALSE;
                end else if ($signed(w_a) <= 64'sd4 || $signed(w_b) <= 64'sd4) begin
                    n_pipe[1].res = WORD_FALSE;
                end else begin
                    n_pipe[1].st = ST_UNSUP;
                end
            end
            K_MUL: ;
            default: begin
                case (n_pipe[1].kind)
                    K_AND:   w_v = w_va & w_vb;
                    K_OR:    w_v = w_va | w_vb;
                    K_XOR:   w_v = w_va ^ w_vb;
                    K_SHL:   w_v = (w_vb[63:6] != '0) ? '0 : (w_va << w_vb[5:0]);
                    K_SHR:   w_v = (w_vb[63:6] != '0) ? '0 : (w_va >> w_vb[5:0]);
                    default: w_v = ~w_va;
                endcase
                n_pipe[1].res = {w_v[62:0], 1'b1};
            end
        endcase
        if (r_s0_word.kind <= 4'(K_GE) && !w_both) begin
            n_pipe[1].res    = WORD_ERR;
            n_pipe[1].st     = ST_UNSUP;
            n_pipe[1].div_go = 1'b0;
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar k = 2; k <= NSTG; k++) begin : g_div
        logic [63:0] w_shf;
        logic [63:0] w_prod;
        logic        w_ge;

        assign w_shf  = {r_pipe[k-1].rem[62:0], r_pipe[k-1].quo[62]};
        assign w_ge   = w_shf >= {1'b0, r_pipe[k-1].dvs};
        assign w_prod = r_pipe[k-1].pll +
                        {r_pipe[k-1].pxa + r_pipe[k-1].pxb, 32'd0};

        always_comb begin
            n_pipe[k]     = r_pipe[k-1];
            n_pipe[k].rem = w_ge ? (w_shf - {1'b0, r_pipe[k-1].dvs}) : w_shf;
            n_pipe[k].quo = {r_pipe[k-1].quo[61:0], w_ge};
            if (k == 2 && r_pipe[k-1].kind == K_MUL && r_pipe[k-1].st == ST_OK) begin
                n_pipe[k].res = {w_prod[62:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 1; k <= NSTG; k++) begin
            if (!i_rst_n) begin
                r_pipe[k].valid <= 1'b0;
            end else if (w_en) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // sign fix and output select
    logic [63:0] w_q, w_r, w_fv;

    always_comb begin
        w_q  = r_pipe[NSTG].q_neg ? -{1'b0, r_pipe[NSTG].quo} : {1'b0, r_pipe[NSTG].quo};
        w_r  = r_pipe[NSTG].r_neg ? -r_pipe[NSTG].rem : r_pipe[NSTG].rem;
        w_fv = (r_pipe[NSTG].kind == K_DIV) ? w_q : w_r;
        n_out_word.result_word = r_pipe[NSTG].div_go ? {w_fv[62:0], 1'b1} : r_pipe[NSTG].res;
        n_out_word.status      = r_pipe[NSTG].st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_pipe[NSTG].valid;
        end
        if (w_en) begin
            r_out_word <= n_out_word;
        end
    end

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.status != ST_OK |-> r_out_word.result_word == WORD_ERR)
        else $error("error status without error word");

    a_ok_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.status == ST_OK |->
        r_out_word.result_word[0] || r_out_word.result_word == WORD_TRUE ||
        r_out_word.result_word == WORD_FALSE)
        else $error("ok result neither tagged nor boolean");

    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en && r_pipe[NSTG].valid |=> r_pipe[NSTG].valid && $stable(r_pipe[NSTG].res))
        else $error("last stage moved during stall");

    a_div_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pipe[1].valid && r_pipe[1].div_go |-> r_pipe[1].st == ST_OK && r_pipe[1].dvs != '0)
        else $error("divide started with bad divisor");

endmodule

[sim/tfa_checker.sv]
// checker for the tagged fixnum alu: predicts each result word and compares it
module tfa_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tfa_pkg::t_in_word   i_in_word,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tfa_pkg::t_out_word  i_out_word,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import tfa_pkg::*;

    t_out_word alu_results_q[$];

    function automatic logic [63:0] untag_word(logic [63:0] w);
        return {w[63], w[63:1]};
    endfunction

    function automatic t_out_word alu_predict(t_in_word w);
        logic [63:0] a, b, ua, ub, va, vb, v, p;
        logic signed [63:0] sa, sb, q;
        t_out_word r;
        a = w.operand_a;
        b = w.operand_b;
        r.result_word = WORD_ERR;
        r.status = ST_OK;
        if (w.kind <= K_GE) begin
            if (!(a[0] && b[0])) begin
                r.status = ST_UNSUP;
            end else begin
                ua = untag_word(a);
                ub = untag_word(b);
                sa = ua;
                sb = ub;
                case (t_kind'(w.kind)) inside
                    K_ADD: r.result_word = a + b - 64'd1;
                    K_SUB: r.result_word = a - b + 64'd1;
                    K_MUL: begin
                        p = ua * ub;
                        r.result_word = {p[62:0], 1'b1};
                    end
                    K_DIV, K_MOD: begin
                        if (sb == 0) begin
                            r.status = ST_DIV0;
                        end else begin
                            q = (w.kind == K_DIV) ? sa / sb : sa % sb;
                            r.result_word = {q[62:0], 1'b1};
                        end
                    end
                    K_LT: r.result_word = (sa < sb) ? WORD_TRUE : WORD_FALSE;
                    K_LE: r.result_word = (sa <= sb) ? WORD_TRUE : WORD_FALSE;
                    K_GT: r.result_word = (sa > sb) ? WORD_TRUE : WORD_FALSE;
                    default: r.result_word = (sa >= sb) ? WORD_TRUE : WORD_FALSE;
                endcase
            end
        end else if (w.kind == K_EQ) begin
            if (a == b) r.result_word = WORD_TRUE;
            else if ((a == 0 && b == 1) || (a == 1 && b == 0)) r.result_word = WORD_TRUE;
            else if (a[0] != b[0]) r.result_word = WORD_FALSE;
            else if (a[0]) r.result_word = WORD_FALSE;
            else if ($signed(a) <= 4 || $signed(b) <= 4) r.result_word = WORD_FALSE;
            else r.status = ST_UNSUP;
        end else begin
            va = a[0] ? untag_word(a) : a;
            vb = b[0] ? untag_word(b) : b;
            case (t_kind'(w.kind))
                K_AND: v = va & vb;
                K_OR:  v = va | vb;
                K_XOR: v = va ^ vb;
                K_SHL: v = (vb >= 64) ? 64'd0 : va << vb;
                K_SHR: v = (vb >= 64) ? 64'd0 : va >> vb;
                default: v = ~va;
            endcase
            r.result_word = {v[62:0], 1'b1};
        end
        return r;
    endfunction

    assign o_pending = alu_results_q.size();

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) alu_results_q.push_back(alu_predict(i_in_word));
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (alu_results_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result word %h", i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_word = alu_results_q.pop_front();
                    if (exp_word.result_word !== i_out_word.result_word
                        || exp_word.status !== i_out_word.status) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %h/%0d got %h/%0d",
                                     exp_word.result_word, exp_word.status,
                                     i_out_word.result_word, i_out_word.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[sim/testbench.sv]
// top of the tagged fixnum alu testbench: stimulus, idling and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_word in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_word out_word;
    int fail_count, pending, result_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int sent_count = 0;

    always #1 i_clk = ~i_clk;

    tagged_fixnum_alu_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_word(out_word)
    );

    tfa_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_word(out_word),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand_operand();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = {{40{w[63]}}, w[23:0]};
            1: w = 64'($urandom_range(8));
            2: w = {63'($urandom_range(70)), 1'b1};
            3: w = {1'b1, 62'd0, 1'b1};
            4: w = {1'b0, {62{1'b1}}, 1'b1};
            5: w = 64'hffff_ffff_ffff_ffff;
            default: ;
        endcase
        if ($urandom_range(9) < 8) w[0] = 1'b1;
        return w;
    endfunction

    task automatic send_word(input logic [3:0] k, input logic [63:0] a, input logic [63:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= '{kind: k, operand_a: a, operand_b: b};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic run_random(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        repeat (n) send_word(4'($urandom_range(15)), rand_operand(), rand_operand());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    localparam logic [63:0] MIN_T = {1'b1, 62'd0, 1'b1};
    localparam logic [63:0] MAX_T = {1'b0, {62{1'b1}}, 1'b1};
    localparam logic [63:0] NEG1_T = 64'hffff_ffff_ffff_ffff;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed corner cases
        send_word(K_ADD, MAX_T, 64'd3);
        send_word(K_SUB, MIN_T, 64'd3);
        send_word(K_MUL, MAX_T, MAX_T);
        send_word(K_DIV, MIN_T, NEG1_T);
        send_word(K_MOD, 64'hfffffffffffffff3, 64'd5);
        send_word(K_DIV, 64'd15, 64'd1);
        send_word(K_MOD, 64'd15, 64'd1);
        send_word(K_ADD, 64'd4, 64'd3);
        send_word(K_LT, MIN_T, MAX_T);
        send_word(K_LE, 64'd7, 64'd7);
        send_word(K_GT, MIN_T, MAX_T);
        send_word(K_GE, NEG1_T, NEG1_T);
        send_word(K_EQ, 64'd0, 64'd1);
        send_word(K_EQ, 64'd8, 64'd8);
        send_word(K_EQ, 64'd8, 64'd16);
        send_word(K_EQ, 64'd2, 64'd16);
        send_word(K_EQ, 64'd3, 64'd6);
        send_word(K_EQ, 64'd3, 64'd5);
        send_word(K_AND, NEG1_T, 64'h8000_0000_0000_0000);
        send_word(K_OR, 64'd6, MIN_T);
        send_word(K_XOR, NEG1_T, 64'h5555_5555_5555_5554);
        send_word(K_SHL, 64'd3, 64'd127);
        send_word(K_SHL, 64'd3, 64'd129);
        send_word(K_SHR, NEG1_T, 64'd64);
        send_word(K_NOT, MAX_T, 64'd0);
        drain();
        run_random(350, 0, 0);
        run_random(350, 82, 0);
        run_random(350, 0, 82);
        run_random(200, 17, 17);
        // long receiver hold-off so the pipeline fills and backs up
        hold_cycles = 300;
        run_random(150, 0, 0);
        drain();
        repeat (80) @(posedge i_clk);
        $display("ran %0d words: corner cases and random operands under mixed idling",
                 sent_count);
        $display("checked %0d result words", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
